>>> hdl/mb2tp_pkg.sv
// Package for the Multiboot2 tag stream parser.
// Result record type, phase codes and status codes. No dependencies.
package mb2tp_pkg;

	localparam logic [1:0] KIND_REGION = 2'd0;
	localparam logic [1:0] KIND_FB     = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_BASE = 3'd1;
	localparam logic [2:0] ST_SHORT    = 3'd2;
	localparam logic [2:0] ST_OVERRUN  = 3'd3;
	localparam logic [2:0] ST_ENTRY    = 3'd4;
	localparam logic [2:0] ST_TOO_MANY = 3'd5;
	localparam logic [2:0] ST_NO_MAP   = 3'd6;

	localparam logic [31:0] TAG_END     = 32'd0;
	localparam logic [31:0] TAG_CMDLINE = 32'd1;
	localparam logic [31:0] TAG_MMAP    = 32'd6;
	localparam logic [31:0] TAG_FB      = 32'd8;
	localparam logic [31:0] TAG_ACPI1   = 32'd14;
	localparam logic [31:0] TAG_ACPI2   = 32'd15;

	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_HEADER = 6'b000010,
		PH_TYPE   = 6'b000100,
		PH_SIZE   = 6'b001000,
		PH_BODY   = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] base;
		logic [63:0] len;
		logic [31:0] rtype;
		logic [31:0] pitch;
		logic [31:0] width;
		logic [31:0] height;
		logic [7:0]  bpp;
		logic [7:0]  fmt;
		logic [12:0] count;
		logic [2:0]  status;
		logic        last;
	} result_t;

	// up to two results per word
	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} pair_t;

endpackage

>>> hdl/mb2tp_front.sv
// Front part: accepts words, walks tags and classifies results.
// Depends on mb2tp_pkg.
module mb2tp_front #(
	parameter int MAX_REGIONS = 64,
	parameter int CW = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [63:0]         cfg_base,
	input  logic                in_go,
	input  logic                start_req,
	input  logic [31:0]         data_word,
	output mb2tp_pkg::pair_t    pair
);
	mb2tp_pkg::phase_t phase_q, ph_n;
	logic [31:0] boff_q, total_q, toff_q, kind_q, tsize_q, stride_q, eoff_q, low_q;
	logic [31:0] boff_n, total_n, toff_n, kind_n, tsize_n, stride_n, eoff_n, low_n;
	logic [63:0] rb_q, rl_q, cmd_q, rsdp_q, fba_q, g0_q, g1_q;
	logic [63:0] rb_n, rl_n, cmd_n, rsdp_n, fba_n, g0_n, g1_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic ovf_q, ovf_n;

	always_comb begin
		logic [32:0] nb, tend, tnext;
		logic [31:0] r, d, eo;
		logic [32:0] tagnx;
		logic [2:0] st_ok;
		logic fin, emitfin, emit0;
		logic [2:0] fst;
		mb2tp_pkg::result_t row;
		ph_n = phase_q; boff_n = boff_q; total_n = total_q; toff_n = toff_q;
		kind_n = kind_q; tsize_n = tsize_q; stride_n = stride_q; eoff_n = eoff_q;
		low_n = low_q; rb_n = rb_q; rl_n = rl_q; cmd_n = cmd_q; rsdp_n = rsdp_q;
		fba_n = fba_q; g0_n = g0_q; g1_n = g1_q; cnt_n = cnt_q; ovf_n = ovf_q;
		fin = 1'b0; emitfin = 1'b0; emit0 = 1'b0; fst = mb2tp_pkg::ST_OK;
		row = '0;
		nb = {1'b0, boff_q} + 33'd4;
		r = boff_q - toff_q;
		d = '0; eo = eoff_q; tend = '0; tnext = '0; tagnx = '0;
		st_ok = ovf_q ? mb2tp_pkg::ST_TOO_MANY
			: ((cnt_q == '0) ? mb2tp_pkg::ST_NO_MAP : mb2tp_pkg::ST_OK);
		if (start_req) begin
			boff_n = 32'd4; total_n = data_word; toff_n = '0; kind_n = '0; tsize_n = '0;
			stride_n = '0; eoff_n = '0; low_n = '0; cnt_n = '0; ovf_n = 1'b0;
			rb_n = '0; rl_n = '0; cmd_n = '0; rsdp_n = '0; fba_n = '0; g0_n = '0; g1_n = '0;
			if (cfg_base == 64'd0 || cfg_base[2:0] != 3'd0) begin
				fin = 1'b1; fst = mb2tp_pkg::ST_BAD_BASE;
			end else if (data_word < 32'd8) begin
				fin = 1'b1; fst = mb2tp_pkg::ST_SHORT;
			end else ph_n = mb2tp_pkg::PH_HEADER;
		end else if (phase_q != mb2tp_pkg::PH_IDLE && phase_q != mb2tp_pkg::PH_DONE) begin
			boff_n = nb[31:0];
			case (phase_q)
				mb2tp_pkg::PH_HEADER: begin
					if (total_q < 32'd16) begin
						fin = 1'b1; fst = st_ok;
					end else begin
						toff_n = 32'd8; ph_n = mb2tp_pkg::PH_TYPE;
					end
				end
				mb2tp_pkg::PH_TYPE: begin
					if (data_word == mb2tp_pkg::TAG_END) begin
						fin = 1'b1; fst = st_ok;
					end else begin
						kind_n = data_word; ph_n = mb2tp_pkg::PH_SIZE;
					end
				end
				mb2tp_pkg::PH_SIZE: begin
					if (data_word < 32'd8 ||
					    {1'b0, toff_q} + {1'b0, data_word} > {1'b0, total_q}) begin
						fin = 1'b1; fst = mb2tp_pkg::ST_OVERRUN;
					end else begin
						tsize_n = data_word;
						if (kind_q == mb2tp_pkg::TAG_CMDLINE)
							cmd_n = cfg_base + {32'd0, toff_q} + 64'd8;
						else if (kind_q == mb2tp_pkg::TAG_ACPI1 || kind_q == mb2tp_pkg::TAG_ACPI2)
							rsdp_n = cfg_base + {32'd0, toff_q} + 64'd8;
						ph_n = mb2tp_pkg::PH_BODY;
					end
				end
				mb2tp_pkg::PH_BODY: begin
					if (r < tsize_q) begin
						if (kind_q == mb2tp_pkg::TAG_MMAP) begin
							if (r == 32'd8) begin
								if (data_word < 32'd24 || data_word[1:0] != 2'd0) begin
									fin = 1'b1; fst = mb2tp_pkg::ST_ENTRY;
								end else begin
									stride_n = data_word; eoff_n = 32'd16;
								end
							end else if (r >= 32'd16 && stride_q >= 32'd24) begin
								d = r - eoff_q;
								if (d >= stride_q) begin
									eo = eoff_q + stride_q; d = d - stride_q;
								end
								eoff_n = eo;
								if ({1'b0, eo} + {1'b0, stride_q} <= {1'b0, tsize_q}) begin
									if (d == 32'd0 || d == 32'd8) low_n = data_word;
									else if (d == 32'd4) rb_n = {data_word, low_q};
									else if (d == 32'd12) rl_n = {data_word, low_q};
									else if (d == 32'd16) begin
										if ({{(32-CW){1'b0}}, cnt_q} >= 32'(MAX_REGIONS))
											ovf_n = 1'b1;
										else begin
											emit0 = 1'b1;
											row.kind = mb2tp_pkg::KIND_REGION;
											row.base = rb_q; row.len = rl_q;
											row.rtype = data_word;
											cnt_n = cnt_q + 1'b1;
										end
									end
								end
							end
						end else if (kind_q == mb2tp_pkg::TAG_FB) begin
							if (r == 32'd8) low_n = data_word;
							else if (r == 32'd12) fba_n = {data_word, low_q};
							else if (r == 32'd16) g0_n = {32'd0, data_word};
							else if (r == 32'd20) g0_n = {data_word, g0_q[31:0]};
							else if (r == 32'd24) g1_n = {32'd0, data_word};
							else if (r == 32'd28 && tsize_q >= 32'd32) begin
								emit0 = 1'b1;
								row.kind = mb2tp_pkg::KIND_FB; row.base = fba_q;
								row.pitch = g0_q[31:0]; row.width = g0_q[63:32];
								row.height = g1_q[31:0];
								row.bpp = data_word[7:0]; row.fmt = data_word[15:8];
							end
						end
					end
				end
				default: ;
			endcase
			// end-of-tag check after size or body word, unless already finished
			if (!fin && (phase_q == mb2tp_pkg::PH_SIZE || phase_q == mb2tp_pkg::PH_BODY)) begin
				tend = {1'b0, toff_q} + {1'b0, tsize_n};
				tnext = {1'b0, toff_q} + (({1'b0, tsize_n} + 33'd7) & ~33'd7);
				tagnx = tnext + 33'd8;
				if (tagnx > {1'b0, total_q}) begin
					if (nb >= tend) begin
						emitfin = 1'b1;
					end
				end else if (nb >= tnext) begin
					toff_n = tnext[31:0]; ph_n = mb2tp_pkg::PH_TYPE;
				end
			end
		end
		pair = '0;
		if (fin || emitfin) ph_n = mb2tp_pkg::PH_DONE;
		if (emitfin) fst = ovf_n ? mb2tp_pkg::ST_TOO_MANY
			: ((cnt_n == '0) ? mb2tp_pkg::ST_NO_MAP : mb2tp_pkg::ST_OK);
		begin
			mb2tp_pkg::result_t fr;
			fr = '0;
			fr.kind = mb2tp_pkg::KIND_DONE; fr.base = cmd_n; fr.len = rsdp_n;
			fr.count = 13'(cnt_n); fr.status = fst; fr.last = 1'b1;
			if (fin) begin
				pair.v0 = 1'b1; pair.r0 = fr;
			end else if (emit0) begin
				pair.v0 = 1'b1; pair.r0 = row; pair.r0.last = !emitfin;
				pair.v1 = emitfin; pair.r1 = fr;
			end else if (emitfin) begin
				pair.v0 = 1'b1; pair.r0 = fr;
			end
		end
		if (!in_go) pair.v0 = 1'b0;
		if (!in_go) pair.v1 = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mb2tp_pkg::PH_IDLE;
			boff_q <= '0; total_q <= '0; toff_q <= '0; kind_q <= '0; tsize_q <= '0;
			stride_q <= '0; eoff_q <= '0; low_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
			rb_q <= '0; rl_q <= '0; cmd_q <= '0; rsdp_q <= '0; fba_q <= '0;
			g0_q <= '0; g1_q <= '0;
		end else if (in_go) begin
			phase_q <= ph_n;
			boff_q <= boff_n; total_q <= total_n; toff_q <= toff_n; kind_q <= kind_n;
			tsize_q <= tsize_n; stride_q <= stride_n; eoff_q <= eoff_n; low_q <= low_n;
			cnt_q <= cnt_n; ovf_q <= ovf_n; rb_q <= rb_n; rl_q <= rl_n; cmd_q <= cmd_n;
			rsdp_q <= rsdp_n; fba_q <= fba_n; g0_q <= g0_n; g1_q <= g1_n;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{{(32-CW){1'b0}}, cnt_q} <= 32'(MAX_REGIONS))
		else $error("region count past limit");
	a_second_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		pair.v1 |-> pair.r1.kind == mb2tp_pkg::KIND_DONE && pair.v0)
		else $error("second result not a completion");
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(in_go && pair.v0 && pair.r0.kind == mb2tp_pkg::KIND_DONE)
		|=> phase_q == mb2tp_pkg::PH_DONE)
		else $error("completion without done phase");
`endif
endmodule

>>> hdl/mb2tp_queue.sv
// Result queue between front and back, two writes and one read per cycle.
// Depends on mb2tp_pkg.
module mb2tp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  mb2tp_pkg::pair_t    pair,
	output logic                room,
	output logic                out_v,
	output mb2tp_pkg::result_t  out_r,
	input  logic                out_take
);
	mb2tp_pkg::result_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic [1:0] nw;

	assign nw = {1'b0, pair.v0} + {1'b0, pair.v1};
	assign room = (cnt_q <= 3'd2);
	assign out_v = (cnt_q != 3'd0);
	assign out_r = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (pair.v0) mem_q[wp_q] <= pair.r0;
		if (pair.v1) mem_q[wp_q + 2'd1] <= pair.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q <= wp_q + nw;
			if (out_take) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, nw} - {2'b0, out_take};
		end
	end

`ifndef SYNTHESIS
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("queue overflow");
	a_no_under: assert property (@(posedge clk) disable iff (!arst_n)
		out_take |-> cnt_q != 3'd0)
		else $error("queue underflow");
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		pair.v1 |-> cnt_q <= 3'd2)
		else $error("double write without room");
`endif
endmodule

>>> hdl/mb2tp_back.sv
// Back part: registered output stage presenting results to the receiver.
// Depends on mb2tp_pkg.
module mb2tp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_v,
	input  mb2tp_pkg::result_t  q_r,
	output logic                q_take,
	output logic                out_valid,
	input  logic                out_ready,
	output mb2tp_pkg::result_t  res
);
	logic v_q;
	mb2tp_pkg::result_t r_q;

	assign q_take = q_v && (!v_q || out_ready);
	assign out_valid = v_q;
	assign res = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else if (!v_q || out_ready) v_q <= q_v;
	end

	always_ff @(posedge clk) begin
		if (q_take) r_q <= q_r;
	end

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q && !out_ready) |=> v_q && $stable(r_q))
		else $error("output changed while stalled");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |=> v_q)
		else $error("taken result not shown");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		v_q |-> r_q.kind != 2'd3)
		else $error("bad result kind");
`endif
endmodule

>>> hdl/multiboot2_tag_stream_parser_unit.sv
// Top level of the Multiboot2 tag stream parser.
// Depends on mb2tp_pkg, mb2tp_front, mb2tp_queue, mb2tp_back.
//
// Input channel: in_valid/in_ready with start_req and data_word, one word
// per transfer. start_req marks word 0 (total size) of a new structure.
// Config channel: cfg_valid/cfg_ready with cfg_data, the structure base
// address; write only while idle.
// Output channel: out_valid/out_ready with one result per transfer: memory
// regions, framebuffer descriptions and one completion summary per start.
// A word yields at most two results; last marks the final one of a word.
// Throughput: one word per cycle while in_ready is high; the front walker
// updates all its state once per word. A word's results are written into the
// queue at its transfer and then into the output register that drives out_valid.
// A four-entry queue decouples the walker from the output register;
// in_ready drops when fewer than two entries are free, so a stalled
// receiver backs up the input after a few results.
// Reset clears the walker to idle, empties the queue and drops out_valid;
// words before the first start are ignored.
module multiboot2_tag_stream_parser_unit #(
	parameter int MAX_REGIONS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        start_req,
	input  logic [31:0] data_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [63:0] result_addr,
	output logic [63:0] region_length,
	output logic [31:0] region_type,
	output logic [31:0] fb_pitch,
	output logic [31:0] fb_width,
	output logic [31:0] fb_height,
	output logic [7:0]  fb_bpp,
	output logic [7:0]  fb_format,
	output logic [6:0]  entry_count,
	output logic [2:0]  status,
	output logic        last
);
	localparam int CW = $clog2(MAX_REGIONS + 1);

	logic [63:0] base_q;
	mb2tp_pkg::pair_t pair;
	mb2tp_pkg::result_t q_r, res;
	logic room, q_v, q_take;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) base_q <= '0;
		else if (cfg_valid) base_q <= cfg_data;
	end

	assign in_ready = room;

	mb2tp_front #(.MAX_REGIONS(MAX_REGIONS), .CW(CW)) u_front (
		.clk, .arst_n, .cfg_base(base_q), .in_go(in_valid && room),
		.start_req, .data_word, .pair
	);
	mb2tp_queue u_queue (
		.clk, .arst_n, .pair, .room, .out_v(q_v), .out_r(q_r), .out_take(q_take)
	);
	mb2tp_back u_back (
		.clk, .arst_n, .q_v, .q_r, .q_take, .out_valid, .out_ready, .res
	);

	assign result_kind   = res.kind;
	assign result_addr   = res.base;
	assign region_length = res.len;
	assign region_type   = res.rtype;
	assign fb_pitch      = res.pitch;
	assign fb_width      = res.width;
	assign fb_height     = res.height;
	assign fb_bpp        = res.bpp;
	assign fb_format     = res.fmt;
	assign entry_count   = res.count[6:0];
	assign status        = res.status;
	assign last          = res.last;
endmodule
